### rtl/apt_pkg.sv
package apt_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INC,
    S_P,
    S_D,
    S_I,
    S_DIFF,
    S_BODY,
    S_LIMST,
    S_LIM,
    S_SAT,
    S_THR,
    S_OUT
  } state_t;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_POS_GAIN      = 3'd0,
    REG_VEL_GAIN      = 3'd1,
    REG_INTEGRAL_GAIN = 3'd2,
    REG_VEHICLE_MASS  = 3'd3,
    REG_ASCENT_LIMIT  = 3'd4
  } reg_idx_t;

  localparam int unsigned CFG_W = 31;

  // True when a wide value falls outside the 32-bit signed range
  function automatic logic ovf32(input logic signed [63:0] x);
    return (x > 64'sd2147483647) || (x < -64'sd2147483648);
  endfunction

  // Clamp a wide value to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/apt_mul.sv
module apt_mul #(
  parameter int AW = 32,
  parameter int BW = 31
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [AW-1:0]        a,
  input  logic        [BW-1:0]        b,
  output logic                        done,
  output logic signed [AW+BW-1:0]     prod
);
  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic signed [PW-1:0] acc_r, acc_nxt;
  logic signed [PW-1:0] mcand_r, mcand_nxt;
  logic        [BW-1:0] mplier_r, mplier_nxt;
  logic        [CW-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;

  assign done = busy_r && (cnt_r == '0);
  assign prod = acc_r;

  // Shift-add: one multiplier bit per cycle, least significant first
  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    if (start) begin
      acc_nxt    = '0;
      mcand_nxt  = PW'(a);
      mplier_nxt = b;
      cnt_nxt    = CW'(BW);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = mcand_r <<< 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    cnt_r    <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

endmodule

### rtl/apt_div.sv
module apt_div #(
  parameter int NW = 50,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW:0]   trial;
  logic          qbit;

  assign done = busy_r && (cnt_r == '0);
  assign quo  = quo_r;

  // Restoring division: one quotient bit per cycle, most significant first
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quo_r[NW-1]};
    qbit     = trial >= {1'b0, den_r};
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (qbit) begin
          rem_nxt = DW'(trial - {1'b0, den_r});
        end else begin
          rem_nxt = trial[DW-1:0];
        end
        quo_nxt = {quo_r[NW-2:0], qbit};
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

endmodule

### rtl/altitude_pid_thrust.sv
// The result follows five passes through the bit-serial multiplier and two through
// the bit-serial divider; a zero tilt cosine or a zero time step each skip one division.
// One item is in flight at a time; the next item is taken while a result waits.
// Reset (rst_n low, synchronous): control and configuration registers to defaults, integral cleared.
module altitude_pid_thrust #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // target_height, target_climb, measured_height, measured_climb,
  // feedforward_accel, tilt_cosine, time_step, zero pad
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [199:0] in_tdata,
  // thrust_cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,
  // saturated
  output logic [0:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import apt_pkg::*;

  localparam int NW  = 34 + FRAC_BITS;
  localparam int BDW = NW + 2;
  localparam logic signed [63:0] G_FIX =
    64'(((64'sd981 * (64'sd1 <<< FRAC_BITS)) + 64'sd50) / 64'sd100);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] pg_r, vg_r, ig_r, mass_r, al_r;
  logic signed [31:0] hes_r, hes_nxt;
  logic signed [31:0] ez_r, ez_nxt, ev_r, ev_nxt, ff_r, ff_nxt, sum_r, sum_nxt;
  logic signed [17:0] cs_r, cs_nxt;
  logic [16:0]        dt_r, dt_nxt;
  logic signed [34:0] acc_r, acc_nxt;
  logic signed [BDW-1:0] body_r, body_nxt;
  logic               neg_r, neg_nxt;
  logic               flag_r, flag_nxt;
  logic signed [31:0] thr_r, thr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_data_r, out_data_nxt;
  logic               out_sat_r, out_sat_nxt;

  // Serial unit hookups
  logic               mul_start, mul_done;
  logic signed [31:0] mul_a;
  logic [30:0]        mul_b;
  logic signed [62:0] mul_prod;
  logic signed [63:0] prod_sh;
  logic               div_start, div_done;
  logic [NW-1:0]      div_num, div_quo;
  logic [17:0]        div_den;

  // Combinational temporaries
  logic signed [63:0] ez_w, ev_w, t64, diff, mag, lim_s, body64;
  logic [17:0]        cs_mag;

  logic cfg_wr;
  logic in_acc;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  assign prod_sh = 64'(mul_prod) >>> FRAC_BITS;

  apt_mul #(.AW(32), .BW(31)) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  apt_div #(.NW(NW), .DW(18)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // Register read mux
  always_comb begin
    case (cfg_paddr[4:2])
      REG_POS_GAIN:      cfg_prdata = {1'b0, pg_r};
      REG_VEL_GAIN:      cfg_prdata = {1'b0, vg_r};
      REG_INTEGRAL_GAIN: cfg_prdata = {1'b0, ig_r};
      REG_VEHICLE_MASS:  cfg_prdata = {1'b0, mass_r};
      REG_ASCENT_LIMIT:  cfg_prdata = {1'b0, al_r};
      default:           cfg_prdata = '0;
    endcase
  end

  // Sequence the arithmetic through the shared multiplier and divider
  always_comb begin
    state_nxt     = state_r;
    hes_nxt       = hes_r;
    ez_nxt        = ez_r;
    ev_nxt        = ev_r;
    ff_nxt        = ff_r;
    sum_nxt       = sum_r;
    cs_nxt        = cs_r;
    dt_nxt        = dt_r;
    acc_nxt       = acc_r;
    body_nxt      = body_r;
    neg_nxt       = neg_r;
    flag_nxt      = flag_r;
    thr_nxt       = thr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_sat_nxt   = out_sat_r;
    mul_start     = 1'b0;
    mul_a         = ez_r;
    mul_b         = pg_r;
    div_start     = 1'b0;
    div_num       = '0;
    div_den       = '0;
    ez_w          = '0;
    ev_w          = '0;
    t64           = '0;
    diff          = acc_r - G_FIX;
    mag           = '0;
    lim_s         = '0;
    body64        = 64'(body_r);
    cs_mag        = '0;

    // Drop the result once the downstream takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ez_w     = 64'($signed(in_tdata[31:0])) - 64'($signed(in_tdata[95:64]));
          ev_w     = 64'($signed(in_tdata[63:32])) - 64'($signed(in_tdata[127:96]));
          ez_nxt   = sat32(ez_w);
          ev_nxt   = sat32(ev_w);
          flag_nxt = ovf32(ez_w) || ovf32(ev_w);
          ff_nxt   = $signed(in_tdata[159:128]);
          cs_nxt   = $signed(in_tdata[177:160]);
          dt_nxt   = in_tdata[194:178];
          mul_start = 1'b1;
          mul_a     = sat32(ez_w);
          mul_b     = 31'(in_tdata[194:178]);
          state_nxt = S_INC;
        end
      end
      S_INC: begin
        if (mul_done) begin
          t64      = 64'(hes_r) + 64'(sat32(prod_sh));
          sum_nxt  = sat32(t64);
          hes_nxt  = sat32(t64);
          flag_nxt = flag_r || ovf32(prod_sh) || ovf32(t64);
          mul_start = 1'b1;
          mul_a     = ez_r;
          mul_b     = pg_r;
          state_nxt = S_P;
        end
      end
      S_P: begin
        if (mul_done) begin
          acc_nxt  = 35'(ff_r) + 35'(sat32(prod_sh));
          flag_nxt = flag_r || ovf32(prod_sh);
          mul_start = 1'b1;
          mul_a     = ev_r;
          mul_b     = vg_r;
          state_nxt = S_D;
        end
      end
      S_D: begin
        if (mul_done) begin
          acc_nxt  = acc_r + 35'(sat32(prod_sh));
          flag_nxt = flag_r || ovf32(prod_sh);
          mul_start = 1'b1;
          mul_a     = sum_r;
          mul_b     = ig_r;
          state_nxt = S_I;
        end
      end
      S_I: begin
        if (mul_done) begin
          t64      = 64'(acc_r) + 64'(sat32(prod_sh));
          acc_nxt  = 35'(sat32(t64));
          flag_nxt = flag_r || ovf32(prod_sh) || ovf32(t64);
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        // Divide (acc - g) by the tilt cosine, or saturate on zero cosine
        if (cs_r == '0) begin
          flag_nxt = 1'b1;
          if (diff > 0) begin
            body_nxt = {2'b01, {NW{1'b0}}};
          end else if (diff < 0) begin
            body_nxt = -{2'b01, {NW{1'b0}}};
          end else begin
            body_nxt = '0;
          end
          state_nxt = S_LIMST;
        end else begin
          mag       = (diff < 0) ? -diff : diff;
          cs_mag    = cs_r[17] ? 18'(-cs_r) : 18'(cs_r);
          div_start = 1'b1;
          div_num   = NW'(mag <<< FRAC_BITS);
          div_den   = cs_mag;
          neg_nxt   = (diff < 0) != cs_r[17];
          state_nxt = S_BODY;
        end
      end
      S_BODY: begin
        if (div_done) begin
          body_nxt  = neg_r ? -BDW'(div_quo) : BDW'(div_quo);
          state_nxt = S_LIMST;
        end
      end
      S_LIMST: begin
        if (dt_r == '0) begin
          flag_nxt  = 1'b1;
          state_nxt = S_SAT;
        end else begin
          div_start = 1'b1;
          div_num   = NW'(al_r) << FRAC_BITS;
          div_den   = {1'b0, dt_r};
          state_nxt = S_LIM;
        end
      end
      S_LIM: begin
        // Bound the body acceleration by the limit over the time step
        if (div_done) begin
          lim_s = 64'(div_quo);
          if (body64 > lim_s) begin
            body_nxt = BDW'(lim_s);
          end else if (body64 < -lim_s) begin
            body_nxt = BDW'(-lim_s);
          end
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        flag_nxt  = flag_r || ovf32(body64);
        mul_start = 1'b1;
        mul_a     = sat32(body64);
        mul_b     = mass_r;
        state_nxt = S_THR;
      end
      S_THR: begin
        if (mul_done) begin
          t64       = -prod_sh;
          thr_nxt   = sat32(t64);
          flag_nxt  = flag_r || ovf32(t64);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = thr_r;
          out_sat_nxt   = flag_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ez_r       <= ez_nxt;
    ev_r       <= ev_nxt;
    ff_r       <= ff_nxt;
    sum_r      <= sum_nxt;
    cs_r       <= cs_nxt;
    dt_r       <= dt_nxt;
    acc_r      <= acc_nxt;
    body_r     <= body_nxt;
    neg_r      <= neg_nxt;
    flag_r     <= flag_nxt;
    thr_r      <= thr_nxt;
    out_data_r <= out_data_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  // Control state, integral and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hes_r       <= '0;
      pg_r        <= '0;
      vg_r        <= '0;
      ig_r        <= '0;
      mass_r      <= CFG_W'(65536);
      al_r        <= CFG_W'(6553600);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hes_r       <= hes_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          REG_POS_GAIN:      pg_r   <= cfg_pwdata[CFG_W-1:0];
          REG_VEL_GAIN:      vg_r   <= cfg_pwdata[CFG_W-1:0];
          REG_INTEGRAL_GAIN: ig_r   <= cfg_pwdata[CFG_W-1:0];
          REG_VEHICLE_MASS:  mass_r <= cfg_pwdata[CFG_W-1:0];
          REG_ASCENT_LIMIT:  al_r   <= cfg_pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule
